@@ rtl/bbpe_pkg.sv @@
`default_nettype none

package bbpe_pkg;

    // number formats
    localparam int COORD_BITS      = 16;
    localparam int PARAM_FRAC_BITS = 16;
    localparam int PARAM_BITS      = PARAM_FRAC_BITS + 1;
    localparam int NUM_COORDS      = 3;
    localparam int WORD_BITS       = COORD_BITS * NUM_COORDS;

    // storage: control grid in the lower half, scratch slots in the upper half
    localparam int GRID_POINTS = 16;
    localparam int RAM_DEPTH   = 2 * GRID_POINTS;
    localparam int ADDR_BITS   = $clog2(RAM_DEPTH);
    localparam int SLOT_BITS   = ADDR_BITS - 1;

    // microprogram
    localparam int STEP_BITS = 5;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic [PARAM_BITS-1:0]        param_t;
    typedef logic [WORD_BITS-1:0]         word_t;
    typedef logic [ADDR_BITS-1:0]         addr_t;
    typedef logic [SLOT_BITS-1:0]         slot_t;
    typedef logic [STEP_BITS-1:0]         step_t;

    localparam param_t PARAM_ONE = param_t'(1 << PARAM_FRAC_BITS);

    localparam logic ACTION_LOAD = 1'b0;
    localparam logic ACTION_EVAL = 1'b1;

    // parameter select
    localparam logic T_U = 1'b0;
    localparam logic T_V = 1'b1;

    // result destination
    localparam logic TO_SCRATCH = 1'b0;
    localparam logic TO_OUTPUT  = 1'b1;

    // sequencing
    localparam logic SEQ_NEXT     = 1'b0;
    localparam logic SEQ_WAIT_END = 1'b1;

    typedef struct packed {
        logic       action;
        logic [3:0] point_index;
        coord_t     coord_x;
        coord_t     coord_y;
        coord_t     coord_z;
        param_t     param_u;
        param_t     param_v;
    } bbpe_in_t;

    typedef struct packed {
        coord_t surf_x;
        coord_t surf_y;
        coord_t surf_z;
    } bbpe_out_t;

    typedef struct packed {
        logic  lerp;
        addr_t addr_a;
        addr_t addr_b;
        slot_t dst;
        logic  use_v;
        logic  to_out;
        logic  seq;
    } ucode_t;

    typedef struct packed {
        logic  en;
        addr_t addr_a;
        addr_t addr_b;
    } rd_ctrl_t;

    typedef struct packed {
        logic  lerp;
        logic  to_out;
        logic  use_v;
        slot_t dst;
    } ex_ctrl_t;

    function automatic addr_t grid_addr(input slot_t p);
        return {1'b0, p};
    endfunction

    function automatic addr_t scr_addr(input slot_t s);
        return {1'b1, s};
    endfunction

    function automatic ucode_t op_lerp(input addr_t a, input addr_t b, input slot_t dst,
                                       input logic use_v, input logic to_out);
        ucode_t w;
        w.lerp   = 1'b1;
        w.addr_a = a;
        w.addr_b = b;
        w.dst    = dst;
        w.use_v  = use_v;
        w.to_out = to_out;
        w.seq    = SEQ_NEXT;
        return w;
    endfunction

    function automatic ucode_t op_nop(input logic seq);
        ucode_t w;
        w        = '0;
        w.seq    = seq;
        return w;
    endfunction

    // scratch use: row q values in slots r*3+i, row r values overwrite them,
    // column values in slots 12..15, column chain reuses slots 0..2
    function automatic ucode_t bbpe_ucode(input step_t step);
        ucode_t w;
        case (step)
            5'd0:  w = op_lerp(grid_addr(4'd0),  grid_addr(4'd1),  4'd0,  T_U, TO_SCRATCH);
            5'd1:  w = op_lerp(grid_addr(4'd1),  grid_addr(4'd2),  4'd1,  T_U, TO_SCRATCH);
            5'd2:  w = op_lerp(grid_addr(4'd2),  grid_addr(4'd3),  4'd2,  T_U, TO_SCRATCH);
            5'd3:  w = op_lerp(grid_addr(4'd4),  grid_addr(4'd5),  4'd3,  T_U, TO_SCRATCH);
            5'd4:  w = op_lerp(grid_addr(4'd5),  grid_addr(4'd6),  4'd4,  T_U, TO_SCRATCH);
            5'd5:  w = op_lerp(grid_addr(4'd6),  grid_addr(4'd7),  4'd5,  T_U, TO_SCRATCH);
            5'd6:  w = op_lerp(grid_addr(4'd8),  grid_addr(4'd9),  4'd6,  T_U, TO_SCRATCH);
            5'd7:  w = op_lerp(grid_addr(4'd9),  grid_addr(4'd10), 4'd7,  T_U, TO_SCRATCH);
            5'd8:  w = op_lerp(grid_addr(4'd10), grid_addr(4'd11), 4'd8,  T_U, TO_SCRATCH);
            5'd9:  w = op_lerp(grid_addr(4'd12), grid_addr(4'd13), 4'd9,  T_U, TO_SCRATCH);
            5'd10: w = op_lerp(grid_addr(4'd13), grid_addr(4'd14), 4'd10, T_U, TO_SCRATCH);
            5'd11: w = op_lerp(grid_addr(4'd14), grid_addr(4'd15), 4'd11, T_U, TO_SCRATCH);
            5'd12: w = op_lerp(scr_addr(4'd0),   scr_addr(4'd1),   4'd0,  T_U, TO_SCRATCH);
            5'd13: w = op_lerp(scr_addr(4'd1),   scr_addr(4'd2),   4'd1,  T_U, TO_SCRATCH);
            5'd14: w = op_lerp(scr_addr(4'd3),   scr_addr(4'd4),   4'd3,  T_U, TO_SCRATCH);
            5'd15: w = op_lerp(scr_addr(4'd4),   scr_addr(4'd5),   4'd4,  T_U, TO_SCRATCH);
            5'd16: w = op_lerp(scr_addr(4'd6),   scr_addr(4'd7),   4'd6,  T_U, TO_SCRATCH);
            5'd17: w = op_lerp(scr_addr(4'd7),   scr_addr(4'd8),   4'd7,  T_U, TO_SCRATCH);
            5'd18: w = op_lerp(scr_addr(4'd9),   scr_addr(4'd10),  4'd9,  T_U, TO_SCRATCH);
            5'd19: w = op_lerp(scr_addr(4'd10),  scr_addr(4'd11),  4'd10, T_U, TO_SCRATCH);
            5'd20: w = op_lerp(scr_addr(4'd0),   scr_addr(4'd1),   4'd12, T_U, TO_SCRATCH);
            5'd21: w = op_lerp(scr_addr(4'd3),   scr_addr(4'd4),   4'd13, T_U, TO_SCRATCH);
            5'd22: w = op_lerp(scr_addr(4'd6),   scr_addr(4'd7),   4'd14, T_U, TO_SCRATCH);
            5'd23: w = op_lerp(scr_addr(4'd9),   scr_addr(4'd10),  4'd15, T_U, TO_SCRATCH);
            5'd24: w = op_lerp(scr_addr(4'd12),  scr_addr(4'd13),  4'd0,  T_V, TO_SCRATCH);
            5'd25: w = op_lerp(scr_addr(4'd13),  scr_addr(4'd14),  4'd1,  T_V, TO_SCRATCH);
            5'd26: w = op_lerp(scr_addr(4'd14),  scr_addr(4'd15),  4'd2,  T_V, TO_SCRATCH);
            5'd27: w = op_lerp(scr_addr(4'd0),   scr_addr(4'd1),   4'd0,  T_V, TO_SCRATCH);
            5'd28: w = op_lerp(scr_addr(4'd1),   scr_addr(4'd2),   4'd1,  T_V, TO_SCRATCH);
            5'd29: w = op_nop(SEQ_NEXT);
            5'd30: w = op_lerp(scr_addr(4'd0),   scr_addr(4'd1),   4'd0,  T_V, TO_OUTPUT);
            5'd31: w = op_nop(SEQ_WAIT_END);
            default: w = op_nop(SEQ_NEXT);
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

@@ rtl/bicubic_bezier_patch_eval.sv @@
`default_nettype none

// channel   direction  handshake          payload
// s_        in         s_valid / s_ready  bbpe_in_t  (load point or evaluate u,v)
// m_        out        m_valid / m_ready  bbpe_out_t (surface point x,y,z)
//
// a load transaction writes one grid point; it gives no result
// an evaluation issues 30 lerps through one shared lerp unit, each dependent
// lerp issued after its operands are written back (registered memory read)
// reset clears the sequencer and output valid; grid points are undefined until loaded
// a finished result waits in the output register while the next transaction is taken;
// a following evaluation holds on its last step until that register frees

module bicubic_bezier_patch_eval (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire bbpe_pkg::bbpe_in_t   s_data,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output bbpe_pkg::bbpe_out_t       m_data
);
    import bbpe_pkg::*;

    // handshake decode
    logic      seq_ready;
    logic      s_accept;
    logic      start;
    logic      load_we;

    // sequencer to datapath
    rd_ctrl_t  rd;
    ex_ctrl_t  ex;

    // datapath
    logic      ram_we;
    addr_t     ram_waddr;
    word_t     ram_wdata;
    word_t     rdata_a;
    word_t     rdata_b;
    word_t     lerp_res;
    param_t    t_sel;
    logic      scratch_we;
    logic      out_load;
    logic      out_busy;

    // parameters of the running evaluation
    param_t    u_reg, u_next;
    param_t    v_reg, v_next;
    param_t    u_clamped;
    param_t    v_clamped;

    // output register
    logic      m_valid_reg, m_valid_next;
    bbpe_out_t m_data_reg, m_data_next;

    assign s_ready  = seq_ready;
    assign s_accept = s_valid && seq_ready;
    assign start    = s_accept && (s_data.action == ACTION_EVAL);
    assign load_we  = s_accept && (s_data.action == ACTION_LOAD);

    // parameters above one clamp to exactly one
    assign u_clamped = (s_data.param_u > PARAM_ONE) ? PARAM_ONE : s_data.param_u;
    assign v_clamped = (s_data.param_v > PARAM_ONE) ? PARAM_ONE : s_data.param_v;
    assign u_next    = start ? u_clamped : u_reg;
    assign v_next    = start ? v_clamped : v_reg;

    // output register occupied and not draining this cycle
    assign out_busy = m_valid_reg && !m_ready;

    bbpe_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (start),
        .out_busy (out_busy),
        .ready    (seq_ready),
        .rd       (rd),
        .ex       (ex)
    );

    // one write port shared by grid loads and scratch results; loads only
    // arrive when the execute stage carries no scratch write
    assign scratch_we = ex.lerp && (ex.to_out == TO_SCRATCH);
    assign ram_we     = load_we || scratch_we;
    assign ram_waddr  = load_we ? grid_addr(s_data.point_index) : scr_addr(ex.dst);
    assign ram_wdata  = load_we ? {s_data.coord_z, s_data.coord_y, s_data.coord_x}
                                : lerp_res;

    bbpe_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .re      (rd.en),
        .raddr_a (rd.addr_a),
        .raddr_b (rd.addr_b),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    assign t_sel = (ex.use_v == T_V) ? v_reg : u_reg;

    bbpe_lerp u_lerp (
        .a_word   (rdata_a),
        .b_word   (rdata_b),
        .t        (t_sel),
        .res_word (lerp_res)
    );

    // final lerp of the column chain lands in the output register
    assign out_load = ex.lerp && (ex.to_out == TO_OUTPUT) && !out_busy;

    assign m_valid_next = out_load ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
    assign m_data_next  = out_load ? bbpe_out_t'({lerp_res[0 +: COORD_BITS],
                                                  lerp_res[COORD_BITS +: COORD_BITS],
                                                  lerp_res[2*COORD_BITS +: COORD_BITS]})
                                   : m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        u_reg      <= u_next;
        v_reg      <= v_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTH
    a_no_result_overwrite : assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> !(m_valid_reg && !m_ready))
        else $error("result written over one still waiting");

    a_single_writer : assert property (@(posedge aclk) disable iff (!aresetn)
        scratch_we |-> !load_we)
        else $error("grid load collides with scratch write");
`endif

endmodule

`default_nettype wire

@@ rtl/bbpe_ram.sv @@
`default_nettype none

module bbpe_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 32
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic      [WIDTH-1:0]         rdata_a,
    output logic      [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

`default_nettype wire

@@ rtl/bbpe_lerp.sv @@
`default_nettype none

module bbpe_lerp (
    input  wire bbpe_pkg::word_t  a_word,
    input  wire bbpe_pkg::word_t  b_word,
    input  wire bbpe_pkg::param_t t,
    output bbpe_pkg::word_t       res_word
);
    import bbpe_pkg::*;

    localparam int DIFF_BITS = COORD_BITS + 1;
    localparam int PROD_BITS = DIFF_BITS + PARAM_BITS + 1;

    logic signed [PARAM_BITS:0] t_s;

    assign t_s = $signed({1'b0, t});

    for (genvar k = 0; k < NUM_COORDS; k++) begin : g_lane
        coord_t                      a;
        coord_t                      b;
        logic signed [DIFF_BITS-1:0] diff;
        logic signed [PROD_BITS-1:0] prod;
        logic signed [PROD_BITS-1:0] quo;

        assign a    = a_word[k*COORD_BITS +: COORD_BITS];
        assign b    = b_word[k*COORD_BITS +: COORD_BITS];
        assign diff = DIFF_BITS'(b) - DIFF_BITS'(a);
        assign prod = PROD_BITS'(diff) * PROD_BITS'(t_s);
        // arithmetic shift gives floor division
        assign quo  = prod >>> PARAM_FRAC_BITS;
        assign res_word[k*COORD_BITS +: COORD_BITS] = a + quo[COORD_BITS-1:0];
    end

endmodule

`default_nettype wire

@@ rtl/bbpe_seq.sv @@
`default_nettype none

module bbpe_seq (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                start,
    input  wire logic                out_busy,
    output logic                     ready,
    output bbpe_pkg::rd_ctrl_t       rd,
    output bbpe_pkg::ex_ctrl_t       ex
);
    import bbpe_pkg::*;

    logic     busy_reg, busy_next;
    step_t    step_reg, step_next;
    ex_ctrl_t ex_reg, ex_next;
    ucode_t   mw;
    logic     last_step;
    logic     hold;

    assign mw        = bbpe_ucode(step_reg);
    assign last_step = busy_reg && (mw.seq == SEQ_WAIT_END);
    // final step waits on itself while the output register is occupied
    assign hold      = last_step && out_busy;
    assign ready     = !busy_reg || (last_step && !out_busy);

    assign rd.en     = busy_reg && !hold && mw.lerp;
    assign rd.addr_a = mw.addr_a;
    assign rd.addr_b = mw.addr_b;
    assign ex        = ex_reg;

    always_comb begin
        busy_next = busy_reg;
        step_next = step_reg;
        ex_next   = ex_reg;
        if (start) begin
            busy_next = 1'b1;
            step_next = '0;
            ex_next   = '0;
        end else if (busy_reg && !hold) begin
            ex_next.lerp   = mw.lerp;
            ex_next.to_out = mw.to_out;
            ex_next.use_v  = mw.use_v;
            ex_next.dst    = mw.dst;
            if (mw.seq == SEQ_WAIT_END) begin
                busy_next = 1'b0;
            end else begin
                step_next = step_reg + 1'b1;
            end
        end else if (!busy_reg) begin
            ex_next.lerp = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= '0;
            ex_reg   <= '0;
        end else begin
            busy_reg <= busy_next;
            step_reg <= step_next;
            ex_reg   <= ex_next;
        end
    end

`ifndef SYNTH
    a_last_step_has_output : assert property (@(posedge aclk) disable iff (!aresetn)
        last_step |-> (ex_reg.lerp && ex_reg.to_out == TO_OUTPUT))
        else $error("final step without output operation in execute stage");

    a_start_at_zero : assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(busy_reg) |-> (step_reg == '0))
        else $error("program started away from its first step");

    a_hold_freezes : assert property (@(posedge aclk) disable iff (!aresetn)
        hold |=> (busy_reg && step_reg == $past(step_reg) && ex_reg == $past(ex_reg)))
        else $error("sequencer moved while waiting on output");
`endif

endmodule

`default_nettype wire
